// ===== rtl/ohash_pkg.sv =====
// ----------------------------------------------------------------------------
// ohash_pkg
// Shared types and constants of the open-addressing hash table core.
// ----------------------------------------------------------------------------
package ohash_pkg;

  localparam int KEY_W    = 34;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  // home slot is reduced 8 key bits per cycle, MSB first
  localparam int HASH_DIGIT = 8;
  localparam int HASH_STEPS = (KEY_W + HASH_DIGIT - 1) / HASH_DIGIT;
  localparam int HASH_W     = HASH_STEPS * HASH_DIGIT;
  localparam int HCNT_W     = $clog2(HASH_STEPS);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic load;          // latch accepted item
    logic hash_step;     // one reduction step of the home slot
    logic probe_step;    // one probe
    logic res_capture;   // park result while the output is busy
    logic out_load;      // load output register
    logic out_from_hold; // output source is the parked result
  } cmd_t;

  typedef struct packed {
    logic hash_last;
    logic probe_done;
  } sts_t;

endpackage

// ===== rtl/ohash_if.sv =====
// ----------------------------------------------------------------------------
// ohash_req_if / ohash_rsp_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface ohash_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ohash_pkg::KEY_W-1:0] key;
  logic                       quadratic;

  modport source (output valid, output op, output key, output quadratic, input ready);
  modport sink   (input valid, input op, input key, input quadratic, output ready);
endinterface

interface ohash_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ohash_pkg::STATUS_W-1:0] status;
  logic [ohash_pkg::POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== rtl/ohash_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohash_ctrl
// Sequencer: accept, home-slot reduction, probing, result hand-off.
// ----------------------------------------------------------------------------
module ohash_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  ohash_pkg::sts_t   sts_i,
  output ohash_pkg::cmd_t   cmd_o
);

  ohash_pkg::state_e state_q, state_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;

  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ohash_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ohash_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ohash_pkg::S_HASH;
        end
      end
      ohash_pkg::S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = ohash_pkg::S_PROBE;
        end
      end
      ohash_pkg::S_PROBE: begin
        cmd_o.probe_step = 1'b1;
        if (sts_i.probe_done) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ohash_pkg::S_IDLE;
          end else begin
            cmd_o.res_capture = 1'b1;
            state_d           = ohash_pkg::S_HOLD;
          end
        end
      end
      ohash_pkg::S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load      = 1'b1;
          cmd_o.out_from_hold = 1'b1;
          state_d             = ohash_pkg::S_IDLE;
        end
      end
      default: state_d = ohash_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

endmodule

// ===== rtl/ohash_dp.sv =====
// ----------------------------------------------------------------------------
// ohash_dp
// Datapath: key latch, home-slot reduction, probe address, key store,
// occupied bits and result registers.
// ----------------------------------------------------------------------------
module ohash_dp #(
  parameter int SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ohash_pkg::cmd_t                  cmd_i,
  output ohash_pkg::sts_t                  sts_o,
  input  logic                             op_i,
  input  logic [ohash_pkg::KEY_W-1:0]      key_i,
  input  logic                             quadratic_i,
  output logic [ohash_pkg::STATUS_W-1:0]   status_o,
  output logic [ohash_pkg::POS_W-1:0]      position_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW = ohash_pkg::KEY_W;
  localparam int PW = ohash_pkg::POS_W;
  localparam int HD = ohash_pkg::HASH_DIGIT;
  localparam int HW = ohash_pkg::HASH_W;
  localparam int CW = ohash_pkg::HCNT_W;

  localparam logic [SW:0]   SLOTS_W   = (SW+1)'(SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [SW:0]   TWO_W     = (SW+1)'(2);
  localparam logic [CW-1:0] HLAST     = CW'(ohash_pkg::HASH_STEPS - 1);

  // item
  logic          op_q;
  logic [KW-1:0] key_q;
  logic          quad_q;

  // home slot reduction
  logic [HW-1:0] ksh_q;
  logic [CW-1:0] hcnt_q;
  logic [SW-1:0] rem_q, rem_d;

  // probing
  logic [SW-1:0] slot_q, slot_lin, slot_quad, slot_nxt;
  logic [SW-1:0] dlt_q, dlt_nxt;
  logic [SW-1:0] pcnt_q;
  logic          p_last;

  // search pipeline, second stage compares read data
  logic          a_act_q;
  logic          b_vld_q, b_last_q, b_occ_q;
  logic [SW-1:0] b_slot_q;

  logic [KW-1:0] mem [SLOTS];
  logic [KW-1:0] rd_key_q;
  logic [SLOTS-1:0] valid_q;
  logic          wr_en;

  logic          is_search;
  logic          ins_free, hit;
  logic          res_done;
  ohash_pkg::status_e res_status;
  logic [SW-1:0] res_slot;
  ohash_pkg::status_e hold_status_q;
  logic [SW-1:0] hold_slot_q;
  logic [SW-1:0] out_slot;
  logic [SW+PW-1:0] pos_ext;
  ohash_pkg::status_e out_status;

  // ---- home slot: remainder by SLOTS, one key byte per cycle -------------
  always_comb begin
    logic [SW:0] t;
    rem_d = rem_q;
    for (int b = 0; b < HD; b++) begin
      t = {rem_d, ksh_q[HW-1-b]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      rem_d = t[SW-1:0];
    end
  end

  assign sts_o.hash_last = (hcnt_q == HLAST);

  // ---- probe sequences ---------------------------------------------------
  always_comb begin
    logic [SW:0] s, d;
    slot_lin = (slot_q == LAST_SLOT) ? '0 : slot_q + SW'(1);
    s = {1'b0, slot_q} + {1'b0, dlt_q};
    if (s >= SLOTS_W) begin
      s = s - SLOTS_W;
    end
    slot_quad = s[SW-1:0];
    // step from i*i to (i+1)*(i+1) is 2i+1
    d = {1'b0, dlt_q} + TWO_W;
    if (d >= SLOTS_W) begin
      d = d - SLOTS_W;
    end
    dlt_nxt = d[SW-1:0];
  end

  assign is_search = (op_q == ohash_pkg::OP_SEARCH);
  assign slot_nxt  = (!is_search && quad_q) ? slot_quad : slot_lin;
  assign p_last    = (pcnt_q == LAST_SLOT);

  assign ins_free = !valid_q[slot_q];
  assign hit      = b_vld_q && b_occ_q && (rd_key_q == key_q);
  assign wr_en    = cmd_i.probe_step && !is_search && ins_free;

  always_comb begin
    if (is_search) begin
      res_done   = hit || (b_vld_q && b_last_q);
      res_status = hit ? ohash_pkg::ST_FOUND : ohash_pkg::ST_MISSING;
      res_slot   = hit ? b_slot_q : '0;
    end else begin
      res_done   = ins_free || p_last;
      res_status = ins_free ? ohash_pkg::ST_INSERTED : ohash_pkg::ST_FULL;
      res_slot   = ins_free ? slot_q : '0;
    end
  end

  assign sts_o.probe_done = res_done;

  // ---- control registers -------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hcnt_q  <= '0;
      a_act_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[slot_q] <= 1'b1;
      end
      if (cmd_i.load) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q + CW'(1);
      end
      if (cmd_i.hash_step && sts_o.hash_last) begin
        a_act_q <= 1'b1;
        b_vld_q <= 1'b0;
      end else if (cmd_i.probe_step) begin
        b_vld_q <= a_act_q;
        if (p_last) begin
          a_act_q <= 1'b0;
        end
      end
    end
  end

  // ---- payload registers -------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      key_q  <= key_i;
      quad_q <= quadratic_i;
      ksh_q  <= {{(HW-KW){1'b0}}, key_i};
      rem_q  <= '0;
    end else if (cmd_i.hash_step) begin
      ksh_q <= ksh_q << HD;
      rem_q <= rem_d;
    end
    if (cmd_i.hash_step && sts_o.hash_last) begin
      slot_q <= rem_d;
      dlt_q  <= SW'(1);
      pcnt_q <= '0;
    end else if (cmd_i.probe_step) begin
      slot_q   <= slot_nxt;
      dlt_q    <= dlt_nxt;
      pcnt_q   <= pcnt_q + SW'(1);
      b_slot_q <= slot_q;
      b_last_q <= p_last;
      b_occ_q  <= valid_q[slot_q];
    end
    if (cmd_i.res_capture) begin
      hold_status_q <= res_status;
      hold_slot_q   <= res_slot;
    end
  end

  // ---- key store ---------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot_q] <= key_q;
    end
    rd_key_q <= mem[slot_q];
  end

  // ---- output register ---------------------------------------------------
  assign out_status = cmd_i.out_from_hold ? hold_status_q : res_status;
  assign out_slot   = cmd_i.out_from_hold ? hold_slot_q : res_slot;
  assign pos_ext    = {{PW{1'b0}}, out_slot};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o   <= out_status;
      position_o <= pos_ext[PW-1:0];
    end
  end

endmodule

// ===== rtl/open_addressing_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Open-addressing hash table of SLOTS numeric keys with linear or quadratic
// insert probing and linear search.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries op (0 insert, 1 search), a 34-bit key and the quadratic
//   flag for inserts. rsp_o returns status (0 inserted, 1 full, 2 found,
//   3 not found) and the low 4 bits of the slot, 0 when there is none.
//   One item is worked at a time. After acceptance the home slot is reduced
//   from the key one byte per cycle, then one slot is probed per cycle.
//   A search compares the key read for a probe in a second stage, since
//   the key store has a registered read port. At the last probe the result
//   is loaded into the output register if that is free; the next item can
//   be taken in the first cycle the result shows on rsp_o.
//   A result that is not taken waits in the output register while the next
//   item is worked; if that item finishes first it parks and the block stalls
//   until the output drains.
//   Reset clears all occupied marks at once; stored keys are not cleared.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core #(
  parameter int SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ohash_req_if.sink  req_i,
  ohash_rsp_if.source rsp_o
);

  ohash_pkg::cmd_t cmd;
  ohash_pkg::sts_t sts;

  ohash_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ohash_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (req_i.op),
    .key_i       (req_i.key),
    .quadratic_i (req_i.quadratic),
    .status_o    (rsp_o.status),
    .position_o  (rsp_o.position)
  );

endmodule
